### rtl/pcfs_pkg.sv
// Shared types, codes and constants of the point charge field summation block.
`default_nettype none

package pcfs_pkg;

    localparam int MAX_PARTICLES_DEF = 64;

    // Item modes
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_DEAD_ZONE = 2'd0;
    localparam logic [1:0] REG_COULOMB   = 2'd1;
    localparam logic [1:0] REG_INV_C2    = 2'd2;

    localparam logic [30:0] DEAD_ZONE_RST = 31'd65536;
    localparam logic [31:0] COULOMB_RST   = 32'd65536;
    localparam logic [31:0] INV_C2_RST    = 32'd65536;

    // Magnitude clip of one contribution and accumulator limits
    localparam logic [46:0] LIM47   = 47'h7FFF_FFFF_FFFF;
    localparam logic [47:0] ACC_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] ACC_MIN = 48'h8000_0000_0000;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
        logic signed [31:0] x_velocity;
        logic signed [31:0] y_velocity;
        logic signed [31:0] charge_value;
    } in_item_t;

    typedef struct packed {
        logic signed [47:0] e_field_x;
        logic signed [47:0] e_field_y;
        logic signed [47:0] b_field_z;
        logic               saturated;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] charge;
    } particle_t;

    typedef struct packed {
        logic [30:0] dead_zone;
        logic [31:0] coulomb_scale;
        logic [31:0] inv_light_speed_sq;
    } field_cfg_t;

    typedef struct packed {
        logic               skip;
        logic               sat;
        logic signed [47:0] ex;
        logic signed [47:0] ey;
        logic signed [47:0] bz;
    } contrib_t;

    typedef enum logic [1:0] {
        T_IDLE,
        T_STEP,
        T_WAIT,
        T_FINISH
    } top_state_t;

    typedef enum logic [3:0] {
        E_IDLE,
        E_MSQX,
        E_MSQY,
        E_SQRT,
        E_CHECK,
        E_MN2,
        E_MKQ,
        E_DIVC,
        E_DIVUX,
        E_DIVUY,
        E_MEX,
        E_MEY,
        E_MP1,
        E_MP2,
        E_MBZ,
        E_DONE
    } eng_state_t;

endpackage

`default_nettype wire

### rtl/pcfs_cell.sv
// One particle cell of the storage ring: load from the append port or take the neighbor's entry.
`default_nettype none

module pcfs_cell
    import pcfs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      load,
    input  wire logic      shift,
    input  wire particle_t load_data,
    input  wire particle_t next_data,
    output particle_t      data
);

    particle_t data_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
        else if (shift)
        begin
            data_reg <= next_data;
        end
    end

    assign data = data_reg;

endmodule

`default_nettype wire

### rtl/pcfs_engine.sv
// Field contribution of one particle: shared 33x16 multiplier, bit-serial root and divider.
`default_nettype none

module pcfs_engine
    import pcfs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [31:0] px,
    input  wire logic signed [31:0] py,
    input  wire particle_t          particle,
    input  wire field_cfg_t         cfg,
    output logic                    done,
    output contrib_t                contrib
);

    eng_state_t state_reg, state_next;

    particle_t   part_reg, part_next;
    logic        dxneg_reg, dxneg_next, dyneg_reg, dyneg_next;
    logic [32:0] adx_reg, adx_next, ady_reg, ady_next;
    logic [65:0] sq_reg, sq_next;
    logic [32:0] root_reg, root_next;
    logic [34:0] rem_reg, rem_next;
    logic [32:0] mul_a_reg, mul_a_next;
    logic [63:0] mul_b_reg, mul_b_next;
    logic [96:0] mul_acc_reg, mul_acc_next;
    logic [1:0]  mcnt_reg, mcnt_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [79:0] div_num_reg, div_num_next;
    logic [64:0] div_den_reg, div_den_next;
    logic [64:0] div_rem_reg, div_rem_next;
    logic [79:0] div_quo_reg, div_quo_next;
    logic [46:0] c_reg, c_next;
    logic [16:0] ux_reg, ux_next, uy_reg, uy_next;
    logic [46:0] ecx_reg, ecx_next, ecy_reg, ecy_next;
    logic [46:0] p1_reg, p1_next, bm_reg, bm_next;
    logic        wneg_reg, wneg_next;
    logic        sat_reg, sat_next, skip_reg, skip_next;

    // Multiplier step: one 16-bit chunk of b per cycle, top chunk first
    logic [48:0] mul_prod;
    logic [96:0] mul_sum;
    logic        mul_last;
    logic        q16_clip;
    logic [46:0] q16_val;

    assign mul_prod = mul_a_reg * mul_b_reg[63:48];
    assign mul_sum  = {mul_acc_reg[80:0], 16'd0} + {48'd0, mul_prod};
    assign mul_last = (mcnt_reg == 2'd3);
    assign q16_clip = (mul_sum[96:63] != '0);
    assign q16_val  = q16_clip ? LIM47 : mul_sum[62:16];

    // Square root step: two radicand bits per cycle
    logic [35:0] rem_sh, trial, rem_sub;
    logic        sqrt_ge;

    assign rem_sh  = {rem_reg[33:0], sq_reg[65:64]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign sqrt_ge = (rem_sh >= trial);
    assign rem_sub = sqrt_ge ? (rem_sh - trial) : rem_sh;

    // Restoring divider step: one quotient bit per cycle
    logic [65:0] div_t, div_sub;
    logic        div_ge;
    logic [79:0] quo_new;

    assign div_t   = {div_rem_reg, div_num_reg[79]};
    assign div_ge  = (div_t >= {1'b0, div_den_reg});
    assign div_sub = div_ge ? (div_t - {1'b0, div_den_reg}) : div_t;
    assign quo_new = {div_quo_reg[78:0], div_ge};

    // Signs and magnitudes
    logic signed [32:0] dx, dy;
    logic [31:0] q_mag, vx_mag, vy_mag;
    logic        qneg, ecx_neg, ecy_neg, p1_neg, p2_neg;
    logic signed [47:0] p1s, p2s;
    logic signed [48:0] w;
    logic [48:0] wm;

    assign dx      = {px[31], px} - {particle.x[31], particle.x};
    assign dy      = {py[31], py} - {particle.y[31], particle.y};
    assign qneg    = part_reg.charge[31];
    assign q_mag   = qneg ? 32'(-part_reg.charge) : 32'(part_reg.charge);
    assign vx_mag  = part_reg.vx[31] ? 32'(-part_reg.vx) : 32'(part_reg.vx);
    assign vy_mag  = part_reg.vy[31] ? 32'(-part_reg.vy) : 32'(part_reg.vy);
    assign ecx_neg = qneg ^ dxneg_reg;
    assign ecy_neg = qneg ^ dyneg_reg;
    assign p1_neg  = part_reg.vx[31] ^ ecy_neg;
    assign p2_neg  = part_reg.vy[31] ^ ecx_neg;
    assign p1s     = p1_neg ? -$signed({1'b0, p1_reg}) : $signed({1'b0, p1_reg});
    assign p2s     = p2_neg ? -$signed({1'b0, q16_val}) : $signed({1'b0, q16_val});
    assign w       = {p1s[47], p1s} - {p2s[47], p2s};
    assign wm      = w[48] ? 49'(-w) : 49'(w);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        part_reg    <= part_next;
        dxneg_reg   <= dxneg_next;
        dyneg_reg   <= dyneg_next;
        adx_reg     <= adx_next;
        ady_reg     <= ady_next;
        sq_reg      <= sq_next;
        root_reg    <= root_next;
        rem_reg     <= rem_next;
        mul_a_reg   <= mul_a_next;
        mul_b_reg   <= mul_b_next;
        mul_acc_reg <= mul_acc_next;
        mcnt_reg    <= mcnt_next;
        cnt_reg     <= cnt_next;
        div_num_reg <= div_num_next;
        div_den_reg <= div_den_next;
        div_rem_reg <= div_rem_next;
        div_quo_reg <= div_quo_next;
        c_reg       <= c_next;
        ux_reg      <= ux_next;
        uy_reg      <= uy_next;
        ecx_reg     <= ecx_next;
        ecy_reg     <= ecy_next;
        p1_reg      <= p1_next;
        bm_reg      <= bm_next;
        wneg_reg    <= wneg_next;
        sat_reg     <= sat_next;
        skip_reg    <= skip_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        part_next    = part_reg;
        dxneg_next   = dxneg_reg;
        dyneg_next   = dyneg_reg;
        adx_next     = adx_reg;
        ady_next     = ady_reg;
        sq_next      = sq_reg;
        root_next    = root_reg;
        rem_next     = rem_reg;
        mul_a_next   = mul_a_reg;
        mul_b_next   = mul_b_reg;
        mul_acc_next = mul_acc_reg;
        mcnt_next    = mcnt_reg;
        cnt_next     = cnt_reg;
        div_num_next = div_num_reg;
        div_den_next = div_den_reg;
        div_rem_next = div_rem_reg;
        div_quo_next = div_quo_reg;
        c_next       = c_reg;
        ux_next      = ux_reg;
        uy_next      = uy_reg;
        ecx_next     = ecx_reg;
        ecy_next     = ecy_reg;
        p1_next      = p1_reg;
        bm_next      = bm_reg;
        wneg_next    = wneg_reg;
        sat_next     = sat_reg;
        skip_next    = skip_reg;
        done         = 1'b0;

        unique case (state_reg)
            E_IDLE:
            begin
                if (start)
                begin
                    part_next    = particle;
                    dxneg_next   = dx[32];
                    dyneg_next   = dy[32];
                    adx_next     = dx[32] ? 33'(-dx) : 33'(dx);
                    ady_next     = dy[32] ? 33'(-dy) : 33'(dy);
                    mul_a_next   = dx[32] ? 33'(-dx) : 33'(dx);
                    mul_b_next   = {31'd0, (dx[32] ? 33'(-dx) : 33'(dx))};
                    mul_acc_next = '0;
                    mcnt_next    = '0;
                    sat_next     = 1'b0;
                    skip_next    = 1'b0;
                    state_next   = E_MSQX;
                end
            end

            E_MSQX:
            begin
                mul_acc_next = mul_sum;
                mul_b_next   = {mul_b_reg[47:0], 16'd0};
                mcnt_next    = mcnt_reg + 2'd1;
                if (mul_last)
                begin
                    sq_next      = {2'b00, mul_sum[63:0]};
                    mul_a_next   = ady_reg;
                    mul_b_next   = {31'd0, ady_reg};
                    mul_acc_next = '0;
                    state_next   = E_MSQY;
                end
            end

            E_MSQY:
            begin
                mul_acc_next = mul_sum;
                mul_b_next   = {mul_b_reg[47:0], 16'd0};
                mcnt_next    = mcnt_reg + 2'd1;
                if (mul_last)
                begin
                    sq_next    = sq_reg + {2'b00, mul_sum[63:0]};
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = 7'd32;
                    state_next = E_SQRT;
                end
            end

            E_SQRT:
            begin
                rem_next  = rem_sub[34:0];
                root_next = {root_reg[31:0], sqrt_ge};
                sq_next   = {sq_reg[63:0], 2'b00};
                cnt_next  = cnt_reg - 7'd1;
                if (cnt_reg == '0)
                begin
                    state_next = E_CHECK;
                end
            end

            E_CHECK:
            begin
                // Drop a particle on the query point or inside the dead zone
                if (root_reg == '0 || root_reg < {2'b00, cfg.dead_zone})
                begin
                    skip_next  = 1'b1;
                    state_next = E_DONE;
                end
                else
                begin
                    mul_a_next   = root_reg;
                    mul_b_next   = {31'd0, root_reg};
                    mul_acc_next = '0;
                    state_next   = E_MN2;
                end
            end

            E_MN2:
            begin
                mul_acc_next = mul_sum;
                mul_b_next   = {mul_b_reg[47:0], 16'd0};
                mcnt_next    = mcnt_reg + 2'd1;
                if (mul_last)
                begin
                    div_den_next = mul_sum[64:0];
                    mul_a_next   = {1'b0, cfg.coulomb_scale};
                    mul_b_next   = {32'd0, q_mag};
                    mul_acc_next = '0;
                    state_next   = E_MKQ;
                end
            end

            E_MKQ:
            begin
                mul_acc_next = mul_sum;
                mul_b_next   = {mul_b_reg[47:0], 16'd0};
                mcnt_next    = mcnt_reg + 2'd1;
                if (mul_last)
                begin
                    div_num_next = {mul_sum[63:0], 16'd0};
                    div_rem_next = '0;
                    div_quo_next = '0;
                    cnt_next     = 7'd79;
                    state_next   = E_DIVC;
                end
            end

            E_DIVC:
            begin
                div_rem_next = div_sub[64:0];
                div_quo_next = quo_new;
                div_num_next = {div_num_reg[78:0], 1'b0};
                cnt_next     = cnt_reg - 7'd1;
                if (cnt_reg == '0)
                begin
                    if (quo_new[79:47] != '0)
                    begin
                        c_next   = LIM47;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        c_next = quo_new[46:0];
                    end
                    div_num_next = {adx_reg, 47'd0};
                    div_den_next = {32'd0, root_reg};
                    div_rem_next = '0;
                    div_quo_next = '0;
                    cnt_next     = 7'd48;
                    state_next   = E_DIVUX;
                end
            end

            E_DIVUX:
            begin
                div_rem_next = div_sub[64:0];
                div_quo_next = quo_new;
                div_num_next = {div_num_reg[78:0], 1'b0};
                cnt_next     = cnt_reg - 7'd1;
                if (cnt_reg == '0)
                begin
                    ux_next      = quo_new[16:0];
                    div_num_next = {ady_reg, 47'd0};
                    div_rem_next = '0;
                    div_quo_next = '0;
                    cnt_next     = 7'd48;
                    state_next   = E_DIVUY;
                end
            end

            E_DIVUY:
            begin
                div_rem_next = div_sub[64:0];
                div_quo_next = quo_new;
                div_num_next = {div_num_reg[78:0], 1'b0};
                cnt_next     = cnt_reg - 7'd1;
                if (cnt_reg == '0)
                begin
                    uy_next      = quo_new[16:0];
                    mul_a_next   = {16'd0, ux_reg};
                    mul_b_next   = {17'd0, c_reg};
                    mul_acc_next = '0;
                    mcnt_next    = '0;
                    state_next   = E_MEX;
                end
            end

            E_MEX:
            begin
                mul_acc_next = mul_sum;
                mul_b_next   = {mul_b_reg[47:0], 16'd0};
                mcnt_next    = mcnt_reg + 2'd1;
                if (mul_last)
                begin
                    ecx_next     = q16_val;
                    sat_next     = sat_reg | q16_clip;
                    mul_a_next   = {16'd0, uy_reg};
                    mul_b_next   = {17'd0, c_reg};
                    mul_acc_next = '0;
                    state_next   = E_MEY;
                end
            end

            E_MEY:
            begin
                mul_acc_next = mul_sum;
                mul_b_next   = {mul_b_reg[47:0], 16'd0};
                mcnt_next    = mcnt_reg + 2'd1;
                if (mul_last)
                begin
                    ecy_next     = q16_val;
                    sat_next     = sat_reg | q16_clip;
                    mul_a_next   = {1'b0, vx_mag};
                    mul_b_next   = {17'd0, q16_val};
                    mul_acc_next = '0;
                    state_next   = E_MP1;
                end
            end

            E_MP1:
            begin
                mul_acc_next = mul_sum;
                mul_b_next   = {mul_b_reg[47:0], 16'd0};
                mcnt_next    = mcnt_reg + 2'd1;
                if (mul_last)
                begin
                    p1_next      = q16_val;
                    sat_next     = sat_reg | q16_clip;
                    mul_a_next   = {1'b0, vy_mag};
                    mul_b_next   = {17'd0, ecx_reg};
                    mul_acc_next = '0;
                    state_next   = E_MP2;
                end
            end

            E_MP2:
            begin
                mul_acc_next = mul_sum;
                mul_b_next   = {mul_b_reg[47:0], 16'd0};
                mcnt_next    = mcnt_reg + 2'd1;
                if (mul_last)
                begin
                    sat_next     = sat_reg | q16_clip;
                    wneg_next    = w[48];
                    mul_a_next   = {1'b0, cfg.inv_light_speed_sq};
                    mul_b_next   = {15'd0, wm};
                    mul_acc_next = '0;
                    state_next   = E_MBZ;
                end
            end

            E_MBZ:
            begin
                mul_acc_next = mul_sum;
                mul_b_next   = {mul_b_reg[47:0], 16'd0};
                mcnt_next    = mcnt_reg + 2'd1;
                if (mul_last)
                begin
                    bm_next    = q16_val;
                    sat_next   = sat_reg | q16_clip;
                    state_next = E_DONE;
                end
            end

            E_DONE:
            begin
                done       = 1'b1;
                state_next = E_IDLE;
            end

            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    assign contrib.skip = skip_reg;
    assign contrib.sat  = sat_reg;
    assign contrib.ex   = ecx_neg ? -$signed({1'b0, ecx_reg}) : $signed({1'b0, ecx_reg});
    assign contrib.ey   = ecy_neg ? -$signed({1'b0, ecy_reg}) : $signed({1'b0, ecy_reg});
    assign contrib.bz   = wneg_reg ? -$signed({1'b0, bm_reg}) : $signed({1'b0, bm_reg});

endmodule

`default_nettype wire

### rtl/point_charge_field_sum.sv
// Top level: particle ring, query sequencing, saturating accumulators and configuration.
// Clear and append transactions produce no result.
// A query walks the ring once. For a stored particle outside the dead zone the engine work
// is dominated by the 80-, 49- and 49-step shared divider and the 33-step root; one inside
// it is dropped after the root; empty slots only shift. Input waits until the query ends.
// Reset clears the particle count and loads 1.0 into all three registers; no memory sweep.
`default_nettype none

module point_charge_field_sum
    import pcfs_pkg::*;
#(
    parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_item_t    in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_item_t        out_data,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    // Count runs to MAX_PARTICLES itself, so its width covers MAX_PARTICLES + 1 values
    localparam int CNT_W = $clog2(MAX_PARTICLES + 1);

    top_state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg, out_data_next;

    logic signed [31:0] qx_reg, qx_next, qy_reg, qy_next;
    logic signed [47:0] ex_reg, ex_next, ey_reg, ey_next, bz_reg, bz_next;
    logic               sat_reg, sat_next;

    logic [30:0] dead_zone_reg;
    logic [31:0] coulomb_reg;
    logic [31:0] inv_c2_reg;

    logic       accept;
    logic       load_en;
    logic       shift;
    logic       eng_start;
    logic       eng_done;
    contrib_t   eng_res;
    field_cfg_t eng_cfg;
    particle_t  new_part;
    particle_t  ring [MAX_PARTICLES];

    logic [48:0] add_x, add_y, add_z;

    // Add with clip to the 48-bit range; the top bit flags a clip
    function automatic logic [48:0] sat_add(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {a[47], a} + {b[47], b};
        if (s[48:47] == 2'b01)
        begin
            return {1'b1, ACC_MAX};
        end
        else if (s[48:47] == 2'b10)
        begin
            return {1'b1, ACC_MIN};
        end
        return {1'b0, s[47:0]};
    endfunction

    assign accept  = in_valid && in_ready;
    assign add_x   = sat_add(ex_reg, eng_res.ex);
    assign add_y   = sat_add(ey_reg, eng_res.ey);
    assign add_z   = sat_add(bz_reg, eng_res.bz);

    assign new_part.x      = in_data.x_coord;
    assign new_part.y      = in_data.y_coord;
    assign new_part.vx     = in_data.x_velocity;
    assign new_part.vy     = in_data.y_velocity;
    assign new_part.charge = in_data.charge_value;

    assign eng_cfg.dead_zone          = dead_zone_reg;
    assign eng_cfg.coulomb_scale      = coulomb_reg;
    assign eng_cfg.inv_light_speed_sq = inv_c2_reg;

    // Storage ring: cell 0 faces the engine, every shift moves each entry one cell down.
    // A full turn of MAX_PARTICLES shifts puts every particle back in its own cell.
    for (genvar i = 0; i < MAX_PARTICLES; i++)
    begin : g_cell
        pcfs_cell u_cell (
            .clk       (clk),
            .load      (load_en && (count_reg == CNT_W'(i))),
            .shift     (shift),
            .load_data (new_part),
            .next_data (ring[(i + 1) % MAX_PARTICLES]),
            .data      (ring[i])
        );
    end

    pcfs_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (eng_start),
        .px       (qx_reg),
        .py       (qy_reg),
        .particle (ring[0]),
        .cfg      (eng_cfg),
        .done     (eng_done),
        .contrib  (eng_res)
    );

    // Configuration registers: writes to an index beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg <= DEAD_ZONE_RST;
            coulomb_reg   <= COULOMB_RST;
            inv_c2_reg    <= INV_C2_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DEAD_ZONE: dead_zone_reg <= cfg_data[30:0];
                REG_COULOMB:   coulomb_reg   <= cfg_data;
                REG_INV_C2:    inv_c2_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qx_reg       <= qx_next;
        qy_reg       <= qy_next;
        ex_reg       <= ex_next;
        ey_reg       <= ey_next;
        bz_reg       <= bz_next;
        sat_reg      <= sat_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        ex_next        = ex_reg;
        ey_next        = ey_reg;
        bz_next        = bz_reg;
        sat_next       = sat_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        load_en        = 1'b0;
        shift          = 1'b0;
        eng_start      = 1'b0;
        in_ready       = (state_reg == T_IDLE);

        unique case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_data.mode)
                        MODE_CLEAR:
                        begin
                            count_next = '0;
                        end
                        MODE_APPEND:
                        begin
                            // Drop the append when the table is full
                            if (count_reg < CNT_W'(MAX_PARTICLES))
                            begin
                                load_en    = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        MODE_QUERY:
                        begin
                            qx_next    = in_data.x_coord;
                            qy_next    = in_data.y_coord;
                            ex_next    = '0;
                            ey_next    = '0;
                            bz_next    = '0;
                            sat_next   = 1'b0;
                            idx_next   = '0;
                            state_next = T_STEP;
                        end
                        default:
                        begin
                            // Unused mode: ignore the transaction
                        end
                    endcase
                end
            end

            T_STEP:
            begin
                if (idx_reg < count_reg)
                begin
                    eng_start  = 1'b1;
                    state_next = T_WAIT;
                end
                else
                begin
                    // Empty slot: advance the ring without work
                    shift = 1'b1;
                    if (idx_reg == CNT_W'(MAX_PARTICLES - 1))
                    begin
                        idx_next   = '0;
                        state_next = T_FINISH;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            T_WAIT:
            begin
                if (eng_done)
                begin
                    if (!eng_res.skip)
                    begin
                        ex_next  = add_x[47:0];
                        ey_next  = add_y[47:0];
                        bz_next  = add_z[47:0];
                        sat_next = sat_reg | eng_res.sat | add_x[48] | add_y[48] | add_z[48];
                    end
                    shift = 1'b1;
                    if (idx_reg == CNT_W'(MAX_PARTICLES - 1))
                    begin
                        idx_next   = '0;
                        state_next = T_FINISH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = T_STEP;
                    end
                end
            end

            T_FINISH:
            begin
                // Hold the sums until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next.e_field_x = ex_reg;
                    out_data_next.e_field_y = ey_reg;
                    out_data_next.b_field_z = bz_reg;
                    out_data_next.saturated = sat_reg;
                    out_valid_next          = 1'b1;
                    state_next              = T_IDLE;
                end
            end

            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The particle count never passes the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_PARTICLES))
        else $error("particle count beyond table size");

    // The engine only finishes while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        eng_done |-> state_reg == T_WAIT)
        else $error("engine transaction finished outside wait state");

    // A finished query stays parked while the previous result is not taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_FINISH && out_valid_reg && !out_ready) |=> state_reg == T_FINISH)
        else $error("query result overwrote a pending result");

    // The ring is back in order whenever the block is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == T_IDLE |-> idx_reg == '0)
        else $error("ring left out of order");

endmodule

`default_nettype wire
